@@ hw/rtl/itd_pkg.sv @@
// Shared types and constants for the 64-bit binary to decimal text converter.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps

package itd_pkg;

    localparam int VALUE_W         = 64;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;
    localparam int FULL_DIGITS     = 20;   // digits of the widest 64-bit magnitude
    localparam int BITS_PER_CYCLE  = 4;
    localparam int CONV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
    localparam int STEP_W          = $clog2(CONV_CYCLES);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // One classified number on its way from the front to the back.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } entry_t;

endpackage

@@ hw/rtl/itd_if.sv @@
// Channel interfaces: number words in, character words out.
// Depends on itd_pkg for field widths.
`timescale 1ns / 1ps

interface itd_num_if;
    logic                         valid;
    logic                         ready;
    logic [itd_pkg::VALUE_W-1:0]  value;
    logic                         twos_comp;

    modport source (output valid, output value, output twos_comp, input ready);
    modport sink   (input valid, input value, input twos_comp, output ready);
endinterface

interface itd_char_if;
    logic                         valid;
    logic                         ready;
    logic [itd_pkg::CHAR_W-1:0]   out_char;
    logic [itd_pkg::LEN_W-1:0]    text_length;
    logic                         last;

    modport source (output valid, output out_char, output text_length, output last,
                    input ready);
    modport sink   (input valid, input out_char, input text_length, input last,
                    output ready);
endinterface

@@ hw/rtl/itd_front.sv @@
// Front end: takes number words, works out sign and magnitude, clamps to the digit budget.
// Depends on itd_pkg and the number channel interface.
`timescale 1ns / 1ps

module itd_front #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    itd_num_if.sink              numbers,
    output logic                 push_valid,
    input  logic                 push_ready,
    output itd_pkg::entry_t      push_entry
);

    function automatic logic [itd_pkg::VALUE_W-1:0] nines(input int d);
        logic [itd_pkg::VALUE_W-1:0] lim;
        lim = itd_pkg::VALUE_W'(1);
        for (int i = 0; i < d; i++)
        begin
            lim = lim * itd_pkg::VALUE_W'(10);
        end
        return lim - itd_pkg::VALUE_W'(1);
    endfunction

    localparam bit                          CLAMP     = MAX_DIGITS < itd_pkg::FULL_DIGITS;
    localparam logic [itd_pkg::VALUE_W-1:0] MAG_LIMIT = nines(MAX_DIGITS);

    logic            stage_valid_reg, stage_valid_next;
    itd_pkg::entry_t entry_reg, entry_next;
    logic            take;
    logic            neg;
    logic [itd_pkg::VALUE_W-1:0] mag;

    assign numbers.ready = !stage_valid_reg || push_ready;
    assign take          = numbers.valid && numbers.ready;

    always_comb
    begin
        neg = numbers.twos_comp && numbers.value[itd_pkg::VALUE_W-1];
        mag = neg ? (~numbers.value + 1'b1) : numbers.value;
        if (CLAMP && (mag > MAG_LIMIT))
        begin
            mag = MAG_LIMIT;
        end
        entry_next       = entry_reg;
        stage_valid_next = stage_valid_reg;
        if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
        if (take)
        begin
            entry_next.neg   = neg;
            entry_next.mag   = mag;
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign push_valid = stage_valid_reg;
    assign push_entry = entry_reg;

endmodule

@@ hw/rtl/itd_queue.sv @@
// Two-entry queue between front and back, so each side can stall on its own.
// Depends on itd_pkg for the entry type.
`timescale 1ns / 1ps

module itd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  itd_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output itd_pkg::entry_t pop_entry
);

    localparam int PTR_W = $clog2(itd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(itd_pkg::QUEUE_DEPTH + 1);

    itd_pkg::entry_t    slots_reg [itd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = count_reg != CNT_W'(itd_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(itd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(itd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/itd_back.sv @@
// Back end: double-dabble conversion four bits a cycle, then one character word a cycle while the receiver is ready.
// Depends on itd_pkg and the character channel interface.
`timescale 1ns / 1ps

module itd_back #(
    parameter int MAX_DIGITS = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  itd_pkg::entry_t pop_entry,
    itd_char_if.source      chars
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_COUNT,
        S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [itd_pkg::VALUE_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]                bcd_reg, bcd_next;
    logic [itd_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            neg_reg, neg_next;
    logic                            sign_pend_reg, sign_pend_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [itd_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                            out_valid_reg, out_valid_next;
    logic [itd_pkg::CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;
    logic [itd_pkg::LEN_W-1:0]       out_len_reg, out_len_next;

    logic [BCD_W-1:0]                bcd_dab;
    logic [itd_pkg::VALUE_W-1:0]     bin_dab;
    logic [CNT_W-1:0]                ndig;
    logic                            slot_free;
    logic [3:0]                      cur_digit;

    // Four shift-and-correct steps of double dabble.
    always_comb
    begin
        bcd_dab = bcd_reg;
        bin_dab = bin_reg;
        for (int s = 0; s < itd_pkg::BITS_PER_CYCLE; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (bcd_dab[d*4 +: 4] >= 4'd5)
                begin
                    bcd_dab[d*4 +: 4] = bcd_dab[d*4 +: 4] + 4'd3;
                end
            end
            bcd_dab = {bcd_dab[BCD_W-2:0], bin_dab[itd_pkg::VALUE_W-1]};
            bin_dab = {bin_dab[itd_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    // Digit count: position of the highest nonzero digit, at least one.
    always_comb
    begin
        ndig = CNT_W'(1);
        for (int d = 1; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                ndig = CNT_W'(d + 1);
            end
        end
    end

    assign slot_free = !out_valid_reg || chars.ready;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign pop_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !chars.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    bin_next   = pop_entry.mag;
                    bcd_next   = '0;
                    neg_next   = pop_entry.neg;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bin_next  = bin_dab;
                bcd_next  = bcd_dab;
                step_next = step_reg + 1'b1;
                if (step_reg == itd_pkg::STEP_W'(itd_pkg::CONV_CYCLES - 1))
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                len_next       = itd_pkg::LEN_W'(ndig) + itd_pkg::LEN_W'(neg_reg);
                idx_next       = IDX_W'(ndig - 1'b1);
                sign_pend_next = neg_reg;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = len_reg;
                    if (sign_pend_reg)
                    begin
                        // a sign is always followed by at least one digit
                        out_char_next  = itd_pkg::CHAR_MINUS;
                        out_last_next  = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next = itd_pkg::CHAR_ZERO + itd_pkg::CHAR_W'(cur_digit);
                        out_last_next = idx_reg == '0;
                        if (idx_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        step_reg      <= step_next;
        neg_reg       <= neg_next;
        sign_pend_reg <= sign_pend_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_len_reg   <= out_len_next;
    end

    assign chars.valid       = out_valid_reg;
    assign chars.out_char    = out_char_reg;
    assign chars.text_length = out_len_reg;
    assign chars.last        = out_last_reg;

endmodule

@@ hw/rtl/int64_to_decimal_text.sv @@
// Each number word (64-bit value plus a two's complement flag) becomes a run of
// ASCII character words, most significant first, an optional '-' then the digits
// with no leading zeros; every word carries the text length and a last flag.
// A number goes through double-dabble conversion (the shared BCD shifter
// handles four bits per cycle), then a digit count, then out one character
// word at a time through the output register, then the back end takes the next.
// The front stage and a two-entry queue hold up to three further numbers while
// the converter works. MAX_DIGITS (3 to 20) sets the digit buffer; larger
// magnitudes clamp to all nines, keeping the sign.
// Depends on itd_pkg, itd_if, itd_front, itd_queue and itd_back.
`timescale 1ns / 1ps

module int64_to_decimal_text #(
    parameter int MAX_DIGITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    itd_num_if.sink     numbers,
    itd_char_if.source  chars
);

    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    itd_pkg::entry_t push_entry, pop_entry;

    itd_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .numbers    (numbers),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    itd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    itd_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .chars     (chars)
    );

endmodule

@@ hw/rtl/itd_checker.sv @@
// Port-level checks on the character output, bound to the top level.
// Depends on itd_pkg and int64_to_decimal_text.
`timescale 1ns / 1ps

module itd_checker #(
    parameter int MAX_DIGITS = 20
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [itd_pkg::CHAR_W-1:0]   out_char,
    input logic [itd_pkg::LEN_W-1:0]    text_length,
    input logic                         last
);

    // Only '-' and decimal digits leave the block.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == itd_pkg::CHAR_MINUS) ||
                      ((out_char >= itd_pkg::CHAR_ZERO) && (out_char <= itd_pkg::CHAR_NINE)))
        else $error("character outside sign and digits");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_length != '0) &&
                      (text_length <= itd_pkg::LEN_W'(MAX_DIGITS + 1)))
        else $error("text length out of range");

    // A sign is never the whole text.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_char == itd_pkg::CHAR_MINUS)) |-> (!last && (text_length > 5'd1)))
        else $error("sign word marked last");

    // Length holds across the words of one text.
    a_len_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (text_length == $past(text_length)))
        else $error("text length changed inside a text");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char) &&
                                       $stable(text_length) && $stable(last)))
        else $error("stalled word changed");

endmodule

bind int64_to_decimal_text itd_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_itd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (chars.valid),
    .out_ready   (chars.ready),
    .out_char    (chars.out_char),
    .text_length (chars.text_length),
    .last        (chars.last)
);

@@ dv/int64_to_decimal_text_test.sv @@
// Self-checking bench for int64_to_decimal_text: drives number words, predicts the
// character words of each number and checks them in order. Depends on itd_pkg,
// itd_if and the converter RTL.
`timescale 1ns / 1ps

module int64_to_decimal_text_test;

    localparam int          DIGITS       = 20;
    localparam int          RANDOM_ITEMS = 320;
    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 60;

    typedef struct {
        logic [itd_pkg::VALUE_W-1:0] value;
        logic                        twos_comp;
        int unsigned                 pause;
    } num_item_t;

    typedef struct {
        logic [itd_pkg::CHAR_W-1:0] out_char;
        logic [itd_pkg::LEN_W-1:0]  text_length;
        logic                       last;
    } char_word_t;

    logic clk = 1'b0;
    logic rst_n;

    itd_num_if  num_bus ();
    itd_char_if char_bus ();

    int64_to_decimal_text #(
        .MAX_DIGITS (DIGITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .numbers (num_bus),
        .chars   (char_bus)
    );

    num_item_t   pending_numbers[$];
    char_word_t  expected_chars[$];
    int unsigned words_total;
    int unsigned words_sent     = 0;
    int unsigned chars_checked  = 0;
    int unsigned negatives_sent = 0;
    int unsigned longest_text   = 0;
    int unsigned failures       = 0;
    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned hold_left;
    logic        hold_off;
    logic        hold_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected text of one number: optional '-', then the digits, most significant first.
    function automatic void push_decimal_text(logic [itd_pkg::VALUE_W-1:0] v, logic s);
        logic [itd_pkg::VALUE_W-1:0] mag;
        logic [itd_pkg::VALUE_W-1:0] lim;
        logic [itd_pkg::CHAR_W-1:0]  digits[itd_pkg::FULL_DIGITS];
        logic                        neg;
        int unsigned                 n;
        int unsigned                 len;
        int unsigned                 pos;
        int                          d;
        char_word_t                  w;

        neg = s && v[itd_pkg::VALUE_W-1];
        mag = neg ? (~v + 64'd1) : v;
        d = DIGITS;
        if (d < 1)
            d = 1;
        if (d > itd_pkg::FULL_DIGITS)
            d = itd_pkg::FULL_DIGITS;
        if (d < itd_pkg::FULL_DIGITS)
        begin
            lim = 64'd1;
            for (int i = 0; i < d; i++)
                lim = lim * 64'd10;
            lim = lim - 64'd1;
            if (mag > lim)
                mag = lim;
        end
        n = 0;
        do
        begin
            digits[n] = itd_pkg::CHAR_ZERO + itd_pkg::CHAR_W'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end
        while (mag != 0 && n < itd_pkg::FULL_DIGITS);

        len = n + (neg ? 1 : 0);
        if (len > longest_text)
            longest_text = len;
        pos = 0;
        if (neg)
        begin
            w.out_char    = itd_pkg::CHAR_MINUS;
            w.text_length = itd_pkg::LEN_W'(len);
            w.last        = (len == 1);
            expected_chars.push_back(w);
            pos = 1;
            negatives_sent++;
        end
        for (int k = 0; k < n; k++)
        begin
            w.out_char    = digits[n - 1 - k];
            w.text_length = itd_pkg::LEN_W'(len);
            w.last        = (pos + 1 == len);
            expected_chars.push_back(w);
            pos++;
        end
    endfunction

    function automatic logic [itd_pkg::VALUE_W-1:0] pow10(int unsigned k);
        logic [itd_pkg::VALUE_W-1:0] p;
        p = 64'd1;
        repeat (k)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic void add_number(logic [itd_pkg::VALUE_W-1:0] v, logic s,
                                       int unsigned pause);
        num_item_t it;
        it.value     = v;
        it.twos_comp = s;
        it.pause     = pause;
        pending_numbers.push_back(it);
    endfunction

    // Random number of a random digit count, negated now and then when signed.
    function automatic void add_random_number(int unsigned pause);
        logic [itd_pkg::VALUE_W-1:0] v;
        logic                        s;
        int unsigned                 mode;

        s = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 3);
        case (mode)
            0: v = {$urandom, $urandom};
            1: v = itd_pkg::VALUE_W'($urandom_range(0, 999));
            2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = pow10($urandom_range(0, 19)) +
                         itd_pkg::VALUE_W'($urandom_range(0, 2)) - 64'd1;
        endcase
        if (mode != 0 && s && $urandom_range(0, 1))
            v = ~v + 64'd1;
        add_number(v, s, pause);
    endfunction

    // Driver: offer the next pending word after its drawn pause; hold while not ready.
    always @(posedge clk or negedge rst_n)
    begin
        num_item_t w;
        if (!rst_n)
        begin
            num_bus.valid     <= 1'b0;
            num_bus.value     <= '0;
            num_bus.twos_comp <= 1'b0;
            idle_left         <= 0;
        end
        else
        begin
            if (num_bus.valid && num_bus.ready)
            begin
                push_decimal_text(num_bus.value, num_bus.twos_comp);
                words_sent++;
            end
            if (num_bus.valid && !num_bus.ready)
            begin
                // hold the word until it is taken
            end
            else if (idle_left != 0)
            begin
                num_bus.valid <= 1'b0;
                idle_left     <= idle_left - 1;
            end
            else if (pending_numbers.size() != 0 && pending_numbers[0].pause != 0)
            begin
                num_bus.valid <= 1'b0;
                idle_left     <= pending_numbers[0].pause - 1;
                pending_numbers[0].pause = 0;
            end
            else if (pending_numbers.size() != 0)
            begin
                w = pending_numbers.pop_front();
                num_bus.valid     <= 1'b1;
                num_bus.value     <= w.value;
                num_bus.twos_comp <= w.twos_comp;
            end
            else
                num_bus.valid <= 1'b0;
        end
    end

    // One long hold-off on the character side so the block fills and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (!hold_done && words_sent >= HOLD_AT)
        begin
            hold_off  <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_off <= 1'b0;
        end
    end

    // Monitor: check each taken character word against the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t  e;
        int unsigned stall_next;
        if (!rst_n)
        begin
            char_bus.ready <= 1'b0;
            stall_left     <= 0;
        end
        else
        begin
            stall_next = (stall_left != 0) ? stall_left - 1 : 0;
            if (char_bus.valid && char_bus.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character word: out_char %h text_length %0d last %0b",
                           char_bus.out_char, char_bus.text_length, char_bus.last);
                    failures++;
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (char_bus.out_char !== e.out_char)
                    begin
                        $error("out_char: expected %h, actual %h", e.out_char, char_bus.out_char);
                        failures++;
                    end
                    if (char_bus.text_length !== e.text_length)
                    begin
                        $error("text_length: expected %0d, actual %0d",
                               e.text_length, char_bus.text_length);
                        failures++;
                    end
                    if (char_bus.last !== e.last)
                    begin
                        $error("last: expected %0b, actual %0b", e.last, char_bus.last);
                        failures++;
                    end
                end
                chars_checked++;
                // stretches with no stalls between stretches of random stalls
                stall_next = ((chars_checked / 64) % 4 == 2) ? 0 : $urandom_range(0, 15);
            end
            stall_left     <= stall_next;
            char_bus.ready <= (stall_next == 0) && !hold_off;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // directed: zero, one-digit edges, digit-count boundaries, sign extremes
        add_number(64'd0, 1'b0, 0);
        add_number(64'd0, 1'b1, 0);
        add_number(64'd1, 1'b0, 0);
        add_number(64'd9, 1'b1, 0);
        add_number(64'd10, 1'b0, 3);
        add_number(64'd99, 1'b0, 0);
        add_number(64'd100, 1'b1, 0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0);
        add_number(64'h8000_0000_0000_0000, 1'b1, 0);
        add_number(64'h8000_0000_0000_0000, 1'b0, 7);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 0);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0);
        add_number(pow10(19) - 64'd1, 1'b0, 0);
        add_number(pow10(19), 1'b0, 0);
        add_number(~64'd10 + 64'd1, 1'b1, 0);
        add_number(~64'd9 + 64'd1, 1'b1, 15);
        add_number(~64'd9 + 64'd1, 1'b0, 0);
        add_number(pow10(18), 1'b1, 0);
        add_number(64'h5555_5555_5555_5555, 1'b0, 0);
        add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 0);
        if (DIGITS < itd_pkg::FULL_DIGITS)
        begin
            add_number(pow10(DIGITS) - 64'd1, 1'b0, 0);
            add_number(pow10(DIGITS), 1'b1, 0);
            add_number(~pow10(DIGITS) + 64'd1, 1'b1, 0);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_number(((i / 32) % 4 == 3) ? 0 : $urandom_range(0, 15));
        words_total = pending_numbers.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (words_sent == words_total);
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (%0d negative) into %0d characters, longest text %0d.",
                 words_sent, negatives_sent, chars_checked, longest_text);
        $display("Random sender gaps and receiver stalls, one long receiver hold-off.");
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d of %0d numbers sent, %0d characters still expected.",
                 words_sent, words_total, expected_chars.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
